// ----- rtl/core/ssbf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssbf_pkg
// types and constants shared by the salted sha-1 bloom filter
// ----------------------------------------------------------------------------
package ssbf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_COUNT  = 3'd0,
        REG_HASH_COUNT = 3'd1,
        REG_SALT_0     = 3'd2,
        REG_SALT_1     = 3'd3,
        REG_SALT_2     = 3'd4,
        REG_SALT_3     = 3'd5,
        REG_SALT_4     = 3'd6,
        REG_SALT_5     = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_CHECK = 1'b1
    } op_t;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_MOD,
        S_RD,
        S_RMW,
        S_DONE
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] w);
        bswap = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ----- rtl/core/ssbf_sha1_round.sv -----
// ----------------------------------------------------------------------------
// ssbf_sha1_round
// one sha-1 round on the working variables
// ----------------------------------------------------------------------------
module ssbf_sha1_round (
    input  logic [6:0]  t,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] e,
    input  logic [31:0] w,
    output logic [31:0] a_out,
    output logic [31:0] c_out
);
    import ssbf_pkg::*;

    logic [31:0] f;
    logic [31:0] k;

    always_comb
    begin
        if (t < 7'd20)
        begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
        end
        else if (t < 7'd40)
        begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
        end
        else if (t < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
        end
        a_out = rotl(a, 5) + f + e + k + w;
        c_out = rotl(b, 30);
    end

endmodule

// ----- rtl/core/salted_sha1_bloom_filter_unit.sv -----
// ----------------------------------------------------------------------------
// salted_sha1_bloom_filter_unit
// bloom filter with salted sha-1 index hashes over a bit memory
// ----------------------------------------------------------------------------
// key bytes arrive one per beat on start/key_byte/last_byte/op while busy is
// low. on the last byte the block runs, for each salt, sha-1 (per 64-byte
// block: a load phase at a byte a cycle, 80 rounds at one a cycle and an
// add step), a bit-serial modulo, and a read-modify-write of the bit memory
// with a synchronous read. a check ends busy early when it meets a clear
// bit; a too-long key skips hashing and goes straight to the done state.
// one status beat per key is shown on result_valid/status for one cycle,
// in the cycle in which busy drops, and the next byte can be taken in that
// same cycle; the receiver cannot stall. after reset the bit memory is
// cleared one word a cycle with busy high; configuration writes are taken
// at any time and must only be issued while idle.
// ----------------------------------------------------------------------------
module salted_sha1_bloom_filter_unit #(
    parameter int MAX_BITS      = 65536,
    parameter int MAX_KEY_BYTES = 64,
    parameter int MAX_HASHES    = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  key_byte,
    input  logic        last_byte,
    input  logic        op,
    output logic        result_valid,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ssbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssbf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssbf_pkg::*;

    localparam int WORDS  = (MAX_BITS + 31) / 32;
    localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IDX_W  = $clog2(MAX_BITS + 1);
    localparam int KA_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KL_W   = $clog2(MAX_KEY_BYTES + 1);
    localparam int MLEN_W = KL_W + 2;
    localparam int BLK_W  = MLEN_W;

    // configuration
    logic [16:0] bit_count_reg;
    logic [3:0]  hash_count_reg;
    logic [63:0] salt_reg [6];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= 17'd65536;
            hash_count_reg <= 4'd1;
            for (int i = 0; i < 6; i++)
                salt_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_BIT_COUNT:  bit_count_reg <= cfg_data[16:0];
                REG_HASH_COUNT: hash_count_reg <= cfg_data[3:0];
                default:        salt_reg[cfg_index - 3'd2] <= cfg_data;
            endcase
        end
    end

    logic [IDX_W-1:0] m_eff;
    logic [3:0]       k_eff;

    always_comb
    begin
        if (bit_count_reg == 17'd0)
            m_eff = IDX_W'(1);
        else if ({15'd0, bit_count_reg} > MAX_BITS)
            m_eff = IDX_W'(MAX_BITS);
        else
            m_eff = IDX_W'(bit_count_reg);
        if (hash_count_reg == 4'd0)
            k_eff = 4'd1;
        else if (hash_count_reg > 4'(MAX_HASHES))
            k_eff = 4'(MAX_HASHES);
        else
            k_eff = hash_count_reg;
    end

    // key memory
    logic [7:0] key_mem [MAX_KEY_BYTES];
    logic [7:0] key_rd_reg;
    logic [KA_W-1:0] key_raddr;

    // bit memory
    logic [31:0] bit_mem [WORDS];
    logic [31:0] bit_rd_reg;
    logic [WA_W-1:0] bit_raddr;
    logic        bit_we;
    logic [WA_W-1:0] bit_waddr;
    logic [31:0] bit_wdata;

    state_t state_reg, state_next;
    logic [KL_W-1:0]   klen_reg;
    logic              kovf_reg;
    logic              op_reg;
    logic [3:0]        hidx_reg;
    logic [BLK_W-1:0]  blk_reg, nblk;
    logic [6:0]        t_reg;
    logic [1:0]        bsel_reg;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]       h_reg [5];
    logic [31:0]       w_reg [16];
    logic [31:0]       wacc_reg;
    logic [31:0]       x_reg;
    logic [IDX_W:0]    rem_reg;
    logic [5:0]        mcnt_reg;
    logic [WA_W-1:0]   clr_reg;
    logic              res_v_reg;
    logic [1:0]        res_reg;

    logic [MLEN_W-1:0] msg_len;
    logic [MLEN_W+5:0] pos;
    logic [7:0]        mbyte;
    logic [31:0]       salt;
    logic [63:0]       bits;
    logic [MLEN_W+5:0] total;

    assign msg_len = MLEN_W'(klen_reg) + MLEN_W'(4);
    assign nblk    = BLK_W'((msg_len + MLEN_W'(8)) >> 6) + BLK_W'(1);
    assign total   = (MLEN_W+6)'(nblk) << 6;
    assign salt    = hidx_reg[0] ? salt_reg[hidx_reg[3:1]][63:32]
                                 : salt_reg[hidx_reg[3:1]][31:0];
    assign bits    = 64'(msg_len) << 3;
    // byte position of the byte being fetched in the load phase
    assign pos     = ((MLEN_W+6)'(blk_reg) << 6) + (MLEN_W+6)'({t_reg[3:0], bsel_reg});

    logic [MLEN_W+5:0] ppos;
    logic [MLEN_W+5:0] lpos;
    always_comb
    begin
        ppos = pos - (MLEN_W+6)'(klen_reg);
        lpos = pos - (total - (MLEN_W+6)'(8));
        if (pos < (MLEN_W+6)'(klen_reg))
            mbyte = key_rd_reg;
        else if (pos < (MLEN_W+6)'(msg_len))
            mbyte = 8'(salt >> {ppos[1:0], 3'b000});
        else if (pos == (MLEN_W+6)'(msg_len))
            mbyte = 8'h80;
        else if (pos >= total - (MLEN_W+6)'(8))
            mbyte = 8'(bits >> {3'd7 - lpos[2:0], 3'b000});
        else
            mbyte = 8'h00;
    end

    // key byte read address runs one beat ahead of pos, byte 0 outside load
    logic [MLEN_W+5:0] pos_ahead;
    assign pos_ahead = pos + (MLEN_W+6)'(1);
    assign key_raddr = (state_reg == S_LOAD) ? KA_W'(pos_ahead) : '0;

    logic start_key;
    logic key_we;
    assign start_key = start && !busy;
    assign key_we    = start_key && klen_reg < KL_W'(MAX_KEY_BYTES);

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[KA_W'(klen_reg)] <= key_byte;
        if (key_we && KA_W'(klen_reg) == key_raddr)
            key_rd_reg <= key_byte;
        else
            key_rd_reg <= key_mem[key_raddr];
    end

    // sha round datapath
    logic [31:0] w_cur, w_new, a_new, c_new;
    assign w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign w_cur = (t_reg < 7'd16) ? w_reg[0] : w_new;

    ssbf_sha1_round u_round (
        .t(t_reg), .a(a_reg), .b(b_reg), .c(c_reg), .d(d_reg), .e(e_reg),
        .w(w_cur), .a_out(a_new), .c_out(c_new)
    );

    logic [31:0] dig_x;
    assign dig_x = bswap(h_reg[0]) ^ bswap(h_reg[1]) ^ bswap(h_reg[2])
                 ^ bswap(h_reg[3]) ^ bswap(h_reg[4]);

    // bit-serial modulo step
    logic [IDX_W:0] rem_sh;
    assign rem_sh = {rem_reg[IDX_W-1:0], x_reg[31]};

    logic [IDX_W-1:0] bidx;
    assign bidx = rem_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == WA_W'(WORDS - 1)) state_next = S_IDLE;
            S_IDLE:
                if (start_key && last_byte)
                    state_next = (kovf_reg || klen_reg >= KL_W'(MAX_KEY_BYTES))
                               ? S_DONE : S_LOAD;
            S_LOAD:
                if (t_reg == 7'd15 && bsel_reg == 2'd3) state_next = S_ROUND;
            S_ROUND: if (t_reg == 7'd79) state_next = S_ADD;
            S_ADD: state_next = (blk_reg + BLK_W'(1) == nblk) ? S_MOD : S_LOAD;
            S_MOD: if (mcnt_reg == 6'd32) state_next = S_RD;
            S_RD:  state_next = S_RMW;
            S_RMW:
                if ((op_reg == OP_CHECK && !bit_rd_reg[bidx[4:0]])
                    || hidx_reg + 4'd1 == k_eff)
                    state_next = S_DONE;
                else
                    state_next = S_LOAD;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        bit_raddr = WA_W'(bidx >> 5);
        bit_we    = 1'b0;
        bit_waddr = WA_W'(bidx >> 5);
        bit_wdata = bit_rd_reg | (32'd1 << bidx[4:0]);
        case (state_reg)
            S_CLEAR:
            begin
                bit_we    = 1'b1;
                bit_waddr = clr_reg;
                bit_wdata = '0;
            end
            S_RMW: bit_we = (op_reg == OP_ADD);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bit_we)
            bit_mem[bit_waddr] <= bit_wdata;
        bit_rd_reg <= bit_mem[bit_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            klen_reg  <= '0;
            kovf_reg  <= 1'b0;
            res_v_reg <= 1'b0;
            res_reg   <= '0;
            hidx_reg  <= '0;
            blk_reg   <= '0;
            t_reg     <= '0;
            bsel_reg  <= '0;
            mcnt_reg  <= '0;
            op_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_v_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: clr_reg <= clr_reg + WA_W'(1);
                S_IDLE:
                    if (start_key)
                    begin
                        if (klen_reg < KL_W'(MAX_KEY_BYTES))
                            klen_reg <= klen_reg + KL_W'(1);
                        else
                            kovf_reg <= 1'b1;
                        op_reg   <= op;
                        hidx_reg <= '0;
                        blk_reg  <= '0;
                        t_reg    <= '0;
                        bsel_reg <= '0;
                        if (last_byte && (kovf_reg || klen_reg >= KL_W'(MAX_KEY_BYTES)))
                            res_reg <= ST_TOO_LONG;
                        else
                            res_reg <= op ? ST_PRESENT : ST_ADDED;
                    end
                S_LOAD:
                begin
                    bsel_reg <= bsel_reg + 2'd1;
                    if (bsel_reg == 2'd3)
                        t_reg <= (t_reg == 7'd15) ? 7'd0 : t_reg + 7'd1;
                end
                S_ROUND: t_reg <= (t_reg == 7'd79) ? 7'd0 : t_reg + 7'd1;
                S_ADD:
                begin
                    blk_reg  <= blk_reg + BLK_W'(1);
                    mcnt_reg <= '0;
                end
                S_MOD: mcnt_reg <= mcnt_reg + 6'd1;
                S_RMW:
                begin
                    hidx_reg <= hidx_reg + 4'd1;
                    blk_reg  <= '0;
                    if (op_reg == OP_CHECK && !bit_rd_reg[bidx[4:0]])
                        res_reg <= ST_ABSENT;
                end
                S_DONE:
                begin
                    res_v_reg <= 1'b1;
                    klen_reg  <= '0;
                    kovf_reg  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LOAD:
            begin
                if (t_reg == 7'd0 && bsel_reg == 2'd0 && blk_reg == '0)
                begin
                    h_reg[0] <= H0; h_reg[1] <= H1; h_reg[2] <= H2;
                    h_reg[3] <= H3; h_reg[4] <= H4;
                    a_reg <= H0; b_reg <= H1; c_reg <= H2; d_reg <= H3; e_reg <= H4;
                end
                else if (t_reg == 7'd0 && bsel_reg == 2'd0)
                begin
                    a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                    d_reg <= h_reg[3]; e_reg <= h_reg[4];
                end
                wacc_reg <= {wacc_reg[23:0], mbyte};
                if (bsel_reg == 2'd3)
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= {wacc_reg[23:0], mbyte};
                end
            end
            S_ROUND:
            begin
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= c_new;
                b_reg <= a_reg;
                a_reg <= a_new;
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_cur;
            end
            S_ADD:
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            S_MOD:
            begin
                if (mcnt_reg == 6'd0)
                begin
                    x_reg   <= dig_x;
                    rem_reg <= '0;
                end
                else
                begin
                    x_reg <= x_reg << 1;
                    if (rem_sh >= (IDX_W+1)'(m_eff))
                        rem_reg <= rem_sh - (IDX_W+1)'(m_eff);
                    else
                        rem_reg <= rem_sh;
                end
            end
            default: ;
        endcase
    end

    assign result_valid = res_v_reg;
    assign status       = res_reg;

endmodule
